// ----- rtl/lfr_pkg.sv -----
package lfr_pkg;

	localparam int FRAME_W     = 6;
	localparam int FRAME_SPACE = 1 << FRAME_W;
	localparam int CMD_W       = 2;
	localparam int COUNT_W     = 7;
	localparam int CAP_W       = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	// register select bit of paddr (word index)
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_VICTIM = 2'd0,
		CMD_PIN    = 2'd1,
		CMD_UNPIN  = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_REMOVE = 2'd1,
		OP_INSERT = 2'd2
	} op_e;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_APPLY = 1'b1
	} state_e;

	typedef struct packed {
		logic capture;
		logic commit;
	} dp_ctrl_t;

endpackage

// ----- rtl/lfr_req_if.sv -----
interface lfr_req_if;
	import lfr_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [FRAME_W-1:0] frame_no;

	modport source (output valid, output command, output frame_no, input ready);
	modport sink (input valid, input command, input frame_no, output ready);
endinterface

// ----- rtl/lfr_rsp_if.sv -----
interface lfr_rsp_if;
	import lfr_pkg::*;

	logic               valid;
	logic               ready;
	logic               victim_found;
	logic [FRAME_W-1:0] victim_frame;
	logic [COUNT_W-1:0] held_count;

	modport source (output valid, output victim_found, output victim_frame,
		output held_count, input ready);
	modport sink (input valid, input victim_found, input victim_frame,
		input held_count, output ready);
endinterface

// ----- rtl/lfr_ctrl.sv -----
module lfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lfr_pkg::dp_ctrl_t dp_ctrl
);
	import lfr_pkg::*;

	state_e state_q;
	state_e state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		dp_ctrl  = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_ctrl.capture = 1'b1;
					state_d         = ST_APPLY;
				end
			end
			ST_APPLY: begin
				// hold the request until the result register is free
				if (!out_valid_q || out_ready) begin
					dp_ctrl.commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/lfr_datapath.sv -----
module lfr_datapath #(
	parameter int SLOTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfr_pkg::dp_ctrl_t           dp_ctrl,
	input  logic [lfr_pkg::CMD_W-1:0]   command,
	input  logic [lfr_pkg::FRAME_W-1:0] frame_no,
	input  logic [lfr_pkg::CAP_W-1:0]   capacity,
	output logic                        victim_found,
	output logic [lfr_pkg::FRAME_W-1:0] victim_frame,
	output logic [lfr_pkg::COUNT_W-1:0] held_count
);
	import lfr_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [FRAME_W-1:0] cell_q [SLOTS];
	logic [SLOTS-1:0]   present_q;
	logic [CW-1:0]      count_q;

	op_e                op_q;
	logic [SLOTS-1:0]   match_q;
	logic [FRAME_W-1:0] frame_q;
	logic               found_q;
	logic [FRAME_W-1:0] vframe_q;

	logic [SLOTS-1:0]   match_cmp;
	logic [SLOTS-1:0]   shift_m;
	logic [CW-1:0]      count_nx;

	op_e                op_d;
	logic [SLOTS-1:0]   match_d;
	logic [FRAME_W-1:0] frame_d;
	logic               found_d;
	logic [FRAME_W-1:0] vframe_d;
	logic               fid_ok;
	logic               room;

	assign fid_ok = 32'(frame_no) < SLOTS;
	assign room   = (count_q < CW'(SLOTS)) && (32'(count_q) < 32'(capacity));

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		localparam logic [SLOTS-1:0] LOW_MASK = {SLOTS{1'b1}} >> (SLOTS - 1 - i);
		logic [FRAME_W-1:0] upper;

		assign match_cmp[i] = (cell_q[i] == frame_no) && (CW'(i) < count_q);
		// a cell moves down when the removed entry sits at or below it
		assign shift_m[i]   = |(match_q & LOW_MASK);

		if (i < SLOTS - 1) begin : g_up
			assign upper = cell_q[i+1];
		end else begin : g_top
			assign upper = cell_q[i];
		end

		always_ff @(posedge clk) begin
			if (dp_ctrl.commit) begin
				if (op_q == OP_REMOVE && shift_m[i]) begin
					cell_q[i] <= upper;
				end else if (op_q == OP_INSERT && count_q == CW'(i)) begin
					cell_q[i] <= frame_q;
				end
			end
		end
	end

	always_comb begin
		op_d     = OP_NONE;
		match_d  = '0;
		frame_d  = frame_no;
		found_d  = 1'b0;
		vframe_d = '0;
		case (command)
			CMD_VICTIM: begin
				if (count_q != '0) begin
					op_d     = OP_REMOVE;
					match_d  = SLOTS'(1);
					frame_d  = cell_q[0];
					found_d  = 1'b1;
					vframe_d = cell_q[0];
				end
			end
			CMD_PIN: begin
				if (fid_ok && present_q[frame_no[IW-1:0]]) begin
					op_d    = OP_REMOVE;
					match_d = match_cmp;
				end
			end
			CMD_UNPIN: begin
				if (fid_ok && !present_q[frame_no[IW-1:0]] && room) begin
					op_d = OP_INSERT;
				end
			end
			default: begin
				op_d = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_NONE;
		end else if (dp_ctrl.capture) begin
			op_q <= op_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.capture) begin
			match_q  <= match_d;
			frame_q  <= frame_d;
			found_q  <= found_d;
			vframe_q <= vframe_d;
		end
	end

	always_comb begin
		case (op_q)
			OP_REMOVE: count_nx = count_q - CW'(1);
			OP_INSERT: count_nx = count_q + CW'(1);
			default:   count_nx = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			present_q <= '0;
		end else if (dp_ctrl.commit) begin
			count_q <= count_nx;
			if (op_q == OP_REMOVE) begin
				present_q[frame_q[IW-1:0]] <= 1'b0;
			end else if (op_q == OP_INSERT) begin
				present_q[frame_q[IW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.commit) begin
			victim_found <= found_q;
			victim_frame <= vframe_q;
			held_count   <= COUNT_W'(count_nx);
		end
	end

endmodule

// ----- rtl/lru_frame_replacer_top.sv -----
// Each request passes two steps: accept with match search, then commit of the shift or insert.
// A new request is taken only once the last one has committed; the row of order cells is the single working unit.
// The result appears in the cycle after commit and holds in an output register until taken;
// a further request is accepted while it waits, and commit stalls only if it is still held.
// Asynchronous active-low reset empties the order and sets capacity to 64; no clearing pass.
module lru_frame_replacer_top #(
	parameter int MAX_FRAMES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lfr_req_if.sink                     req,
	lfr_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lfr_pkg::APB_AW-1:0]  paddr,
	input  logic [lfr_pkg::APB_DW-1:0]  pwdata,
	output logic [lfr_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import lfr_pkg::*;

	localparam int SLOTS = (MAX_FRAMES < FRAME_SPACE) ? MAX_FRAMES : FRAME_SPACE;

	logic [CAP_W-1:0] capacity_q;
	logic             cap_sel;
	dp_ctrl_t         dp_ctrl;

	assign pready  = 1'b1;
	assign cap_sel = paddr[APB_AW-1] == REG_CAPACITY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && cap_sel) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = cap_sel ? APB_DW'(capacity_q) : '0;

	lfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.dp_ctrl   (dp_ctrl)
	);

	lfr_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_ctrl      (dp_ctrl),
		.command      (req.command),
		.frame_no     (req.frame_no),
		.capacity     (capacity_q),
		.victim_found (rsp.victim_found),
		.victim_frame (rsp.victim_frame),
		.held_count   (rsp.held_count)
	);

endmodule

// ----- rtl/lfr_checker.sv -----
module lfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_victim_found,
	input logic [lfr_pkg::FRAME_W-1:0] rsp_victim_frame,
	input logic [lfr_pkg::COUNT_W-1:0] rsp_held_count
);
	import lfr_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// one request at a time: no back-to-back accept
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request accepted while previous one in progress");

	// with the result register empty, the result follows accept through the commit state without a stall
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && !rsp_valid) |-> ##2 rsp_valid)
		else $error("result missing two cycles after request");

	// and the input side reopens at the same time
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && !rsp_valid) |-> ##2 req_ready)
		else $error("request side did not reopen after commit");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_victim_found) &&
			$stable(rsp_victim_frame) && $stable(rsp_held_count)))
		else $error("stalled result changed");

endmodule

bind lru_frame_replacer_top lfr_checker u_lfr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_victim_found (rsp.victim_found),
	.rsp_victim_frame (rsp.victim_frame),
	.rsp_held_count   (rsp.held_count)
);

// ----- tb/lru_frame_replacer_checker.sv -----
module lru_frame_replacer_checker
	import lfr_pkg::*;
#(
	parameter int MAX_FRAMES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	lfr_req_if                req,
	lfr_rsp_if                rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] frame;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	logic [FRAME_W-1:0]    lru_order[$];
	logic [MAX_FRAMES-1:0] held_map = '0;
	logic [CAP_W-1:0]      capacity = CAP_RESET;
	outcome_t              awaited_outcomes[$];
	int                    fail_tally = 0;

	assign mismatches = fail_tally;

	function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
		input logic [FRAME_W-1:0] fid);
		outcome_t o;
		int limit;
		int pos;
		o = '0;
		limit = (int'(capacity) > MAX_FRAMES) ? MAX_FRAMES : int'(capacity);
		pos = -1;
		case (cmd)
			CMD_VICTIM: begin
				if (lru_order.size() > 0) begin
					o.found = 1'b1;
					o.frame = lru_order.pop_front();
					held_map[o.frame] = 1'b0;
				end
			end
			CMD_PIN: begin
				if (int'(fid) < MAX_FRAMES && held_map[fid]) begin
					for (int i = 0; i < lru_order.size(); i++)
						if (pos < 0 && lru_order[i] == fid)
							pos = i;
					if (pos >= 0)
						lru_order.delete(pos);
					held_map[fid] = 1'b0;
				end
			end
			CMD_UNPIN: begin
				// refuse while at or above capacity, even if capacity was lowered under the count
				if (int'(fid) < MAX_FRAMES && !held_map[fid] && lru_order.size() < limit) begin
					lru_order.push_back(fid);
					held_map[fid] = 1'b1;
				end
			end
			default: ;
		endcase
		o.count = COUNT_W'(lru_order.size());
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			lru_order.delete();
			awaited_outcomes.delete();
			held_map = '0;
			capacity = CAP_RESET;
			outstanding <= 0;
		end else begin
			// check the result before recording the request taken at the same edge
			if (rsp.valid && rsp.ready) begin
				got.found = rsp.victim_found;
				got.frame = rsp.victim_frame;
				got.count = rsp.held_count;
				if (awaited_outcomes.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual found=%0d frame=%0d count=%0d",
						$time, got.found, got.frame, got.count);
					fail_tally++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (got.found !== want.found) begin
						$display("%0t: victim_found expected %0d actual %0d",
							$time, want.found, got.found);
						fail_tally++;
					end
					if (got.frame !== want.frame) begin
						$display("%0t: victim_frame expected %0d actual %0d",
							$time, want.frame, got.frame);
						fail_tally++;
					end
					if (got.count !== want.count) begin
						$display("%0t: held_count expected %0d actual %0d",
							$time, want.count, got.count);
						fail_tally++;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_outcomes.push_back(apply_command(req.command, req.frame_no));
			if (psel && penable && pready && paddr[2] == REG_CAPACITY) begin
				if (pwrite) begin
					capacity = pwdata[CAP_W-1:0];
				end else if (prdata[CAP_W-1:0] !== capacity) begin
					$display("%0t: capacity read expected %0d actual %0d",
						$time, capacity, prdata[CAP_W-1:0]);
					fail_tally++;
				end
			end
			outstanding <= awaited_outcomes.size();
		end
	end

endmodule

// ----- tb/lru_frame_replacer_top_tb.sv -----
module lru_frame_replacer_top_tb;
	import lfr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_FRAMES  = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 10;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [APB_AW-1:0] ADDR_CAPACITY = APB_AW'({REG_CAPACITY, 2'b00});
	localparam logic [APB_AW-1:0] ADDR_UNUSED   = APB_AW'({~REG_CAPACITY, 2'b00});

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                mismatches;
	int                outstanding;
	int                cycle_count = 0;
	bit                hold_rsp = 1'b0;

	lfr_req_if req_ch ();
	lfr_rsp_if rsp_ch ();

	lru_frame_replacer_top #(
		.MAX_FRAMES(MAX_FRAMES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	lru_frame_replacer_checker #(
		.MAX_FRAMES(MAX_FRAMES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// hold the request until taken; leave valid high for a back-to-back request
	task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] fid,
		input int gap);
		req_ch.valid    <= 1'b1;
		req_ch.command  <= cmd;
		req_ch.frame_no <= fid;
		do @(posedge clk); while (!req_ch.ready);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_items(input int count, input int w_unpin, input int w_pin,
		input int w_victim, input bit gapless);
		int r;
		logic [CMD_W-1:0] cmd;
		logic [FRAME_W-1:0] fid;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < w_unpin)
				cmd = CMD_UNPIN;
			else if (r < w_unpin + w_pin)
				cmd = CMD_PIN;
			else if (r < w_unpin + w_pin + w_victim)
				cmd = CMD_VICTIM;
			else
				cmd = CMD_UNKNOWN;
			// favour a small pool of frames so that pins find held entries
			if ($urandom_range(0, 99) < 40)
				fid = FRAME_W'($urandom_range(0, 15));
			else
				fid = FRAME_W'($urandom());
			push_request(cmd, fid, (gapless || i < 30) ? 0 : pick_gap());
		end
	endtask

	task automatic run_phase(input logic [CAP_W-1:0] cap, input int count, input int w_unpin,
		input int w_pin, input int w_victim);
		logic [APB_DW-1:0] data;
		drain_results();
		data = $urandom();
		data[CAP_W-1:0] = cap;
		reg_access(1'b1, ADDR_CAPACITY, data);
		reg_access(1'b0, ADDR_CAPACITY, '0);
		reg_access(1'b1, ADDR_UNUSED, $urandom());
		random_items(count, w_unpin, w_pin, w_victim, 1'b0);
	endtask

	initial begin : rsp_drive
		int r;
		int run;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					rsp_ch.ready <= 1'b1;
					run = (r < 8) ? $urandom_range(100, 200) : $urandom_range(1, 20);
				end else begin
					rsp_ch.ready <= 1'b0;
					run = 1 + pick_gap();
				end
				// cut the run short as soon as a long hold is requested
				for (int k = 0; k < run && !hold_rsp; k++)
					@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		req_ch.valid    <= 1'b0;
		req_ch.command  <= CMD_VICTIM;
		req_ch.frame_no <= '0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		arst_n          <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty set, duplicates, unknown command, removal at both ends and middle
		push_request(CMD_VICTIM, 6'd0, pick_gap());
		push_request(CMD_PIN, 6'd0, pick_gap());
		push_request(CMD_UNPIN, 6'd0, pick_gap());
		push_request(CMD_UNPIN, 6'd63, pick_gap());
		push_request(CMD_UNPIN, 6'd0, pick_gap());
		push_request(CMD_UNKNOWN, 6'd63, pick_gap());
		push_request(CMD_PIN, 6'd63, pick_gap());
		push_request(CMD_VICTIM, 6'd63, pick_gap());
		push_request(CMD_VICTIM, 6'd0, pick_gap());
		push_request(CMD_UNPIN, 6'd5, 0);
		push_request(CMD_UNPIN, 6'd6, 0);
		push_request(CMD_UNPIN, 6'd7, 0);
		push_request(CMD_UNPIN, 6'd42, pick_gap());
		push_request(CMD_PIN, 6'd6, pick_gap());
		push_request(CMD_VICTIM, 6'd0, pick_gap());
		push_request(CMD_PIN, 6'd42, pick_gap());
		push_request(CMD_UNPIN, 6'd6, pick_gap());
		push_request(CMD_VICTIM, 6'd0, 0);
		push_request(CMD_VICTIM, 6'd0, 0);
		push_request(CMD_VICTIM, 6'd0, pick_gap());
		push_request(CMD_UNKNOWN, 6'd0, pick_gap());
		push_request(CMD_UNPIN, 6'd21, pick_gap());
		push_request(CMD_PIN, 6'd21, pick_gap());
		drain_results();

		// fill at reset capacity, then stall the result side while requests keep coming
		random_items(150, 70, 12, 14, 1'b0);
		hold_rsp = 1'b1;
		random_items(80, 70, 12, 14, 1'b1);
		drain_results();
		random_items(70, 50, 20, 26, 1'b0);

		// capacity lowered below the count first, then empty, tiny, oversized and back
		run_phase(7'd3, 180, 45, 25, 26);
		run_phase(7'd0, 150, 50, 15, 31);
		run_phase(7'd1, 180, 50, 22, 24);
		run_phase(7'd127, 280, 86, 5, 6);
		run_phase(CAP_RESET, 180, 40, 28, 28);
		run_phase(7'd20, 180, 55, 20, 21);
		run_phase(CAP_W'($urandom_range(2, 63)), 180, 55, 20, 21);

		drain_results();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lfr_pkg.sv
rtl/lfr_req_if.sv
rtl/lfr_rsp_if.sv
rtl/lfr_ctrl.sv
rtl/lfr_datapath.sv
rtl/lru_frame_replacer_top.sv
rtl/lfr_checker.sv
tb/lru_frame_replacer_checker.sv
tb/lru_frame_replacer_top_tb.sv
